@@ rtl/core/src_pkg.sv @@
// package: widths, types and helpers for the segment rectangle clipper
`default_nettype none
package src_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int T_FRAC = 32;
    // quotient magnitude width: 30 integer bits plus 32 fraction bits
    localparam int QM_W = 62;
    localparam int T_W = 64;

    // one segment after nudging, with its deltas and window edges chosen
    typedef struct packed {
        logic signed [64:0] x1;
        logic signed [64:0] y1;
        logic signed [64:0] x2;
        logic signed [64:0] y2;
        logic signed [65:0] dx;
        logic signed [65:0] dy;
        logic signed [64:0] xin;
        logic signed [64:0] xout;
        logic signed [64:0] yin;
        logic signed [64:0] yout;
    } seg_t;

    // state of one divider lane inside a cell
    typedef struct packed {
        logic [65:0] rem;
        logic [65:0] den;
        logic [QM_W-1:0] quo;
        logic neg;
        logic sat;
    } div_t;
endpackage
`default_nettype wire

@@ rtl/core/segment_rectangle_clipper_core.sv @@
// top level: segment clipper with nudge front end, divider cell chain and
// output stages
//
// a segment passes through 69 register stages (1 setup, 62 divider cells,
// 6 back-end stages); throughput one segment per cycle, set by the chain of
// divider cells each taking one quotient bit; a stalled output stalls the
// whole pipeline.
// reset clears the window registers to zero and empties the pipeline.
`default_nettype none
module segment_rectangle_clipper_core
#(
    parameter int COORD_WIDTH = src_pkg::COORD_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_we,
    input  wire logic [1:0]               cfg_index,
    input  wire logic [COORD_WIDTH-1:0]   cfg_data,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, end_x, end_y from the low bits up
    input  wire logic [4*COORD_WIDTH-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // hit, entry_x, entry_y, exit_x, exit_y from the low bits up, zero fill
    output logic [((4*COORD_WIDTH+1+7)/8)*8-1:0] m_tdata
);
    import src_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int NCELL = QM_W;
    localparam int OUT_W = ((4*CW+1+7)/8)*8;
    localparam int NBACK = 6;

    localparam logic [1:0] REG_LEFT = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP = 2'd3;

    logic signed [CW-1:0] wxa_reg, wxb_reg, wya_reg, wyb_reg;
    logic adv;

    assign adv = m_tready || !m_tvalid;
    assign s_tready = adv;

    // window registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wxa_reg <= '0;
            wxb_reg <= '0;
            wya_reg <= '0;
            wyb_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT:   wxa_reg <= cfg_data;
                REG_RIGHT:  wxb_reg <= cfg_data;
                REG_BOTTOM: wya_reg <= cfg_data;
                REG_TOP:    wyb_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // front end: nudge endpoints, fix zero deltas, pick in and out edges
    seg_t seg_next;
    always_comb
    begin
        logic signed [64:0] sx, sy, ex, ey, wa, wb, va, vb;
        sx = 65'(signed'(s_tdata[CW-1:0]));
        sy = 65'(signed'(s_tdata[2*CW-1:CW]));
        ex = 65'(signed'(s_tdata[3*CW-1:2*CW]));
        ey = 65'(signed'(s_tdata[4*CW-1:3*CW]));
        wa = 65'(wxa_reg); wb = 65'(wxb_reg);
        va = 65'(wya_reg); vb = 65'(wyb_reg);
        seg_next.x1 = (sx == wa || sx == wb) ? sx + 65'sd1 : sx;
        seg_next.x2 = (ex == wa || ex == wb) ? ex + 65'sd1 : ex;
        seg_next.y1 = (sy == va || sy == vb) ? sy + 65'sd1 : sy;
        seg_next.y2 = (ey == va || ey == vb) ? ey + 65'sd1 : ey;
        seg_next.dx = 66'(seg_next.x2) - 66'(seg_next.x1);
        seg_next.dy = 66'(seg_next.y2) - 66'(seg_next.y1);
        if (seg_next.dx == 66'sd0)
            seg_next.dx = (seg_next.x1 > wa) ? -66'sd1 : 66'sd1;
        if (seg_next.dy == 66'sd0)
            seg_next.dy = (seg_next.y1 > va) ? -66'sd1 : 66'sd1;
        seg_next.xin  = (seg_next.dx > 0) ? wa : wb;
        seg_next.xout = (seg_next.dx > 0) ? wb : wa;
        seg_next.yin  = (seg_next.dy > 0) ? va : vb;
        seg_next.yout = (seg_next.dy > 0) ? vb : va;
    end

    logic vld0_reg;
    seg_t seg0_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld0_reg <= 1'b0;
        else if (adv)
            vld0_reg <= s_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
            seg0_reg <= seg_next;
    end

    // divider setup: integer part decides saturation, quotient bits by the chain
    function automatic div_t div_init(input logic signed [65:0] n,
                                      input logic signed [65:0] d);
        div_t r;
        logic [65:0] an, ad;
        an = n[65] ? 66'(-n) : 66'(n);
        ad = d[65] ? 66'(-d) : 66'(d);
        // integer quotient at or above 2^30 means an >= ad * 2^30
        r.sat = (ad[65:36] == '0) && (an >= {ad[35:0], 30'd0});
        r.neg = n[65] != d[65];
        r.den = ad;
        r.rem = r.sat ? 66'd0 : (an >> 30);
        // low 30 numerator bits and 32 zero fraction bits are fed in by the chain
        r.quo = {an[29:0], 32'd0};
        return r;
    endfunction

    // long division over 62 steps on (an << 32), dividend bits shift out of quo
    seg_t seg_c [0:NCELL];
    div_t [3:0] dv_c [0:NCELL];
    logic vld_c [0:NCELL];

    assign dv_c[0][0] = div_init(66'(seg0_reg.xin) - 66'(seg0_reg.x1), seg0_reg.dx);
    assign dv_c[0][1] = div_init(66'(seg0_reg.yin) - 66'(seg0_reg.y1), seg0_reg.dy);
    assign dv_c[0][2] = div_init(66'(seg0_reg.xout) - 66'(seg0_reg.x1), seg0_reg.dx);
    assign dv_c[0][3] = div_init(66'(seg0_reg.yout) - 66'(seg0_reg.y1), seg0_reg.dy);
    assign seg_c[0] = seg0_reg;
    assign vld_c[0] = vld0_reg;

    genvar g;
    generate
        for (g = 0; g < NCELL; g++)
        begin : g_cell
            src_div_cell u_cell
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .en      (adv),
                .vld_in  (vld_c[g]),
                .seg_in  (seg_c[g]),
                .dv_in   (dv_c[g]),
                .vld_out (vld_c[g+1]),
                .seg_out (seg_c[g+1]),
                .dv_out  (dv_c[g+1])
            );
        end
    endgenerate

    // signed t values out of the chain
    logic signed [T_W-1:0] tq [4];
    always_comb
    begin
        logic [T_W-1:0] m;
        for (int i = 0; i < 4; i++)
        begin
            m = dv_c[NCELL][i].sat ? (64'd1 << 62) : 64'(dv_c[NCELL][i].quo);
            tq[i] = dv_c[NCELL][i].neg ? -signed'(m) : signed'(m);
        end
    end

    // back end stage a: compare and choose
    localparam logic signed [T_W-1:0] T_ONE = 64'sd1 << T_FRAC;
    logic va_reg, hit_a_reg, in_t_reg, out_t_reg, in_y_reg, out_y_reg;
    logic signed [T_W-1:0] ti_reg, to_reg;
    seg_t sa_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            va_reg <= 1'b0;
        else if (adv)
            va_reg <= vld_c[NCELL];
    end
    always_ff @(posedge clk)
    begin
        logic signed [T_W-1:0] tin1, tin2, tout1;
        if (adv)
        begin
            tin1 = (tq[0] < tq[1]) ? tq[0] : tq[1];
            tin2 = (tq[0] < tq[1]) ? tq[1] : tq[0];
            tout1 = (tq[2] < tq[3]) ? tq[2] : tq[3];
            hit_a_reg <= tin1 <= T_ONE && tin2 <= T_ONE &&
                         (tin2 >= 0 || tout1 >= 0) && tin2 <= tout1;
            in_t_reg  <= tin2 > 0;
            out_t_reg <= tout1 < T_ONE;
            in_y_reg  <= !(tq[0] > tq[1]);
            out_y_reg <= !(tq[2] < tq[3]);
            ti_reg <= (tq[0] > tq[1]) ? tq[0] : tq[1];
            to_reg <= (tq[2] < tq[3]) ? tq[2] : tq[3];
            sa_reg <= seg_c[NCELL];
        end
    end

    // stage b: clamp t, pick multiplicand delta and take its magnitude and sign
    logic vb_reg, hit_b_reg, in_t_b, out_t_b, in_y_b, out_y_b;
    logic [32:0] ti_b, to_b;
    logic [65:0] ai_b, ao_b;
    logic ni_b, no_b;
    seg_t sb_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vb_reg <= 1'b0;
        else if (adv)
            vb_reg <= va_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [65:0] di, dq;
        if (adv)
        begin
            ti_b <= (ti_reg < 0) ? 33'd0 : (ti_reg > T_ONE) ? 33'h100000000 : ti_reg[32:0];
            to_b <= (to_reg < 0) ? 33'd0 : (to_reg > T_ONE) ? 33'h100000000 : to_reg[32:0];
            di = in_y_reg ? sa_reg.dx : sa_reg.dy;
            dq = out_y_reg ? sa_reg.dx : sa_reg.dy;
            ni_b <= di[65];
            no_b <= dq[65];
            ai_b <= di[65] ? 66'(-di) : 66'(di);
            ao_b <= dq[65] ? 66'(-dq) : 66'(dq);
            hit_b_reg <= hit_a_reg;
            in_t_b <= in_t_reg; out_t_b <= out_t_reg;
            in_y_b <= in_y_reg; out_y_b <= out_y_reg;
            sb_reg <= sa_reg;
        end
    end

    // stage c: partial products, 32x32 pieces
    logic vc_reg, hit_c, in_t_c, out_t_c, in_y_c, out_y_c, ni_c, no_c;
    logic [63:0] pi_lo, po_lo, pi_hi, po_hi;
    logic [65:0] ai_c, ao_c;
    logic ti1_c, to1_c;
    seg_t sc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vc_reg <= 1'b0;
        else if (adv)
            vc_reg <= vb_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pi_lo <= 64'(ai_b[31:0]) * 64'(ti_b[31:0]);
            po_lo <= 64'(ao_b[31:0]) * 64'(to_b[31:0]);
            pi_hi <= 64'(ai_b[63:32]) * 64'(ti_b[31:0]);
            po_hi <= 64'(ao_b[63:32]) * 64'(to_b[31:0]);
            ti1_c <= ti_b[32]; to1_c <= to_b[32];
            ai_c <= ai_b; ao_c <= ao_b;
            ni_c <= ni_b; no_c <= no_b;
            hit_c <= hit_b_reg; in_t_c <= in_t_b; out_t_c <= out_t_b;
            in_y_c <= in_y_b; out_y_c <= out_y_b;
            sc_reg <= sb_reg;
        end
    end

    // stage d: sum pieces into magnitude and sign it
    logic vd_reg, hit_d, in_t_d, out_t_d, in_y_d, out_y_d;
    logic signed [67:0] mi_d, mo_d;
    seg_t sd_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd_reg <= 1'b0;
        else if (adv)
            vd_reg <= vc_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [67:0] mi, mo;
        if (adv)
        begin
            // deltas fit in 33 bits, so the high piece covers delta bits 63:32
            mi = (ti1_c ? 68'(ai_c) : 68'd0) + 68'(pi_hi) + 68'(pi_lo[63:32]);
            mo = (to1_c ? 68'(ao_c) : 68'd0) + 68'(po_hi) + 68'(po_lo[63:32]);
            mi_d <= ni_c ? -signed'(mi) : signed'(mi);
            mo_d <= no_c ? -signed'(mo) : signed'(mo);
            hit_d <= hit_c; in_t_d <= in_t_c; out_t_d <= out_t_c;
            in_y_d <= in_y_c; out_y_d <= out_y_c;
            sd_reg <= sc_reg;
        end
    end

    // stage e: form points
    logic ve_reg, hit_e;
    logic signed [68:0] ex_e, ey_e, ox_e, oy_e;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ve_reg <= 1'b0;
        else if (adv)
            ve_reg <= vd_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_e <= hit_d;
            if (!in_t_d)
            begin
                ex_e <= 69'(sd_reg.x1); ey_e <= 69'(sd_reg.y1);
            end
            else if (!in_y_d)
            begin
                ex_e <= 69'(sd_reg.xin); ey_e <= 69'(sd_reg.y1) + 69'(mi_d);
            end
            else
            begin
                ex_e <= 69'(sd_reg.x1) + 69'(mi_d); ey_e <= 69'(sd_reg.yin);
            end
            if (!out_t_d)
            begin
                ox_e <= 69'(sd_reg.x2); oy_e <= 69'(sd_reg.y2);
            end
            else if (!out_y_d)
            begin
                ox_e <= 69'(sd_reg.xout); oy_e <= 69'(sd_reg.y1) + 69'(mo_d);
            end
            else
            begin
                ox_e <= 69'(sd_reg.x1) + 69'(mo_d); oy_e <= 69'(sd_reg.yout);
            end
        end
    end

    // saturate a point coordinate to the coordinate range
    function automatic logic [CW-1:0] sat_c(input logic signed [68:0] v);
        logic signed [68:0] hi, lo;
        hi = 69'((70'sd1 <<< (CW-1)) - 70'sd1);
        lo = -hi - 69'sd1;
        if (v > hi) return hi[CW-1:0];
        if (v < lo) return lo[CW-1:0];
        return v[CW-1:0];
    endfunction

    // output register
    logic vo_reg;
    logic [OUT_W-1:0] do_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (adv)
            vo_reg <= ve_reg;
    end
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            do_reg <= '0;
            if (hit_e)
                do_reg <= OUT_W'({sat_c(oy_e), sat_c(ox_e), sat_c(ey_e), sat_c(ex_e), 1'b1});
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = do_reg;
endmodule
`default_nettype wire

@@ rtl/core/src_div_cell.sv @@
// one cell of the divider chain: one quotient bit per lane per cycle while en is high
`default_nettype none
module src_div_cell
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  wire src_pkg::seg_t        seg_in,
    input  wire src_pkg::div_t [3:0]  dv_in,
    output logic                      vld_out,
    output src_pkg::seg_t             seg_out,
    output src_pkg::div_t [3:0]       dv_out
);
    import src_pkg::*;

    logic vld_reg;
    seg_t seg_reg;
    div_t [3:0] dv_reg, dv_next;

    // restoring step on each lane, next dividend bit comes from the quotient msb
    always_comb
    begin
        logic [66:0] sh;
        for (int i = 0; i < 4; i++)
        begin
            dv_next[i] = dv_in[i];
            sh = {dv_in[i].rem, dv_in[i].quo[QM_W-1]};
            dv_next[i].quo = {dv_in[i].quo[QM_W-2:0], 1'b0};
            if (sh >= {1'b0, dv_in[i].den})
            begin
                sh = sh - {1'b0, dv_in[i].den};
                dv_next[i].quo[0] = 1'b1;
            end
            dv_next[i].rem = sh[65:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            seg_reg <= seg_in;
            dv_reg  <= dv_next;
        end
    end

    assign vld_out = vld_reg;
    assign seg_out = seg_reg;
    assign dv_out  = dv_reg;
endmodule
`default_nettype wire

@@ test/segment_rectangle_clipper_core_tb.sv @@
// testbench: segment rectangle clipper core, checked against a behavioral predictor
`default_nettype none
module segment_rectangle_clipper_core_tb;
    localparam int CW = 32;
    localparam int OW = ((4*CW+1+7)/8)*8;
    localparam longint T_ONE = 64'sd1 <<< 32;
    localparam longint T_SAT = 64'sd1 <<< 62;
    localparam logic [1:0] REG_LEFT = 2'd0;
    localparam logic [1:0] REG_RIGHT = 2'd1;
    localparam logic [1:0] REG_BOTTOM = 2'd2;
    localparam logic [1:0] REG_TOP = 2'd3;
    localparam int LATENCY = 69;
    localparam longint CYCLE_LIMIT = 400000;
    localparam int N_RANDOM = 750;

    typedef struct packed {
        logic        hit;
        logic [31:0] entry_x;
        logic [31:0] entry_y;
        logic [31:0] exit_x;
        logic [31:0] exit_y;
    } clip_t;

    typedef struct {
        logic [31:0] sx, sy, ex, ey;
        logic        known;
        clip_t       res;
    } vec_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_we;
    logic [1:0]    cfg_index;
    logic [CW-1:0] cfg_data;
    logic          s_tvalid;
    logic          s_tready;
    logic [4*CW-1:0] s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [OW-1:0] m_tdata;

    longint win_left, win_right, win_bottom, win_top;
    clip_t  pending_clips[$];
    int     error_count;
    longint cycle_count;
    bit     quiet_sides;

    segment_rectangle_clipper_core i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic longint nudge_coord(longint c, longint e1, longint e2);
        return (c == e1 || c == e2) ? c + 1 : c;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // quotient with 32 fraction bits, saturating
    function automatic longint t_quotient(longint n, longint d);
        logic [127:0] an, ad, q;
        longint mag;
        an = abs64(n);
        ad = abs64(d);
        if (ad == 0) ad = 1;
        if (an / ad >= (128'd1 << 30)) mag = T_SAT;
        else
        begin
            q = (an << 32) / ad;
            mag = longint'(q[63:0]);
        end
        return ((n < 0) != (d < 0)) ? -mag : mag;
    endfunction

    // t times delta, truncated toward zero
    function automatic longint t_scale(longint t, longint d);
        logic [127:0] p;
        longint mag;
        if (t < 0) t = 0;
        if (t > T_ONE) t = T_ONE;
        p = 128'(abs64(d)) * 128'(t);
        mag = longint'(p[95:32]);
        return d < 0 ? -mag : mag;
    endfunction

    function automatic logic [31:0] clamp_coord(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic clip_t clip_segment(logic [31:0] sx, logic [31:0] sy,
                                           logic [31:0] ex, logic [31:0] ey);
        longint x1, y1, x2, y2, dx, dy, xin, xout, yin, yout;
        longint tinx, tiny, toutx, touty, tin1, tin2, tout1, px, py, qx, qy;
        clip_t r;
        r = '0;
        x1 = nudge_coord(longint'($signed(sx)), win_left, win_right);
        y1 = nudge_coord(longint'($signed(sy)), win_bottom, win_top);
        x2 = nudge_coord(longint'($signed(ex)), win_left, win_right);
        y2 = nudge_coord(longint'($signed(ey)), win_bottom, win_top);
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) dx = (x1 > win_left) ? -1 : 1;
        if (dy == 0) dy = (y1 > win_bottom) ? -1 : 1;
        if (dx > 0) begin xin = win_left; xout = win_right; end
        else begin xin = win_right; xout = win_left; end
        if (dy > 0) begin yin = win_bottom; yout = win_top; end
        else begin yin = win_top; yout = win_bottom; end
        tinx = t_quotient(xin - x1, dx);
        tiny = t_quotient(yin - y1, dy);
        toutx = t_quotient(xout - x1, dx);
        touty = t_quotient(yout - y1, dy);
        if (tinx < tiny) begin tin1 = tinx; tin2 = tiny; end
        else begin tin1 = tiny; tin2 = tinx; end
        tout1 = (toutx < touty) ? toutx : touty;
        if (tin1 > T_ONE || tin2 > T_ONE) return r;
        if (tin2 < 0 && tout1 < 0) return r;
        if (tin2 > tout1) return r;
        if (tin2 > 0)
        begin
            if (tinx > tiny) begin px = xin; py = y1 + t_scale(tinx, dy); end
            else begin px = x1 + t_scale(tiny, dx); py = yin; end
        end
        else
        begin
            px = x1; py = y1;
        end
        if (tout1 < T_ONE)
        begin
            if (toutx < touty) begin qx = xout; qy = y1 + t_scale(toutx, dy); end
            else begin qx = x1 + t_scale(touty, dx); qy = yout; end
        end
        else
        begin
            qx = x2; qy = y2;
        end
        r.hit = 1'b1;
        r.entry_x = clamp_coord(px);
        r.entry_y = clamp_coord(py);
        r.exit_x = clamp_coord(qx);
        r.exit_y = clamp_coord(qy);
        return r;
    endfunction

    function automatic clip_t unpack_result(logic [OW-1:0] d);
        clip_t r;
        r.hit = d[0];
        r.entry_x = d[32:1];
        r.entry_y = d[64:33];
        r.exit_x = d[96:65];
        r.exit_y = d[128:97];
        return r;
    endfunction

    // result checker and output stall
    always @(posedge clk)
    begin
        clip_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = unpack_result(m_tdata);
                if (pending_clips.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = pending_clips.pop_front();
                    if (got.hit !== want.hit)
                        $display("%0t: hit exp %0b got %0b", $time, want.hit, got.hit);
                    if (got.entry_x !== want.entry_x)
                        $display("%0t: entry_x exp %h got %h", $time, want.entry_x, got.entry_x);
                    if (got.entry_y !== want.entry_y)
                        $display("%0t: entry_y exp %h got %h", $time, want.entry_y, got.entry_y);
                    if (got.exit_x !== want.exit_x)
                        $display("%0t: exit_x exp %h got %h", $time, want.exit_x, got.exit_x);
                    if (got.exit_y !== want.exit_y)
                        $display("%0t: exit_y exp %h got %h", $time, want.exit_y, got.exit_y);
                    if (got !== want) error_count++;
                end
            end
            m_tready <= quiet_sides || ($urandom_range(99) >= 7);
        end
    end

    task automatic write_window(logic [1:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LEFT:   win_left = longint'($signed(value));
            REG_RIGHT:  win_right = longint'($signed(value));
            REG_BOTTOM: win_bottom = longint'($signed(value));
            default:    win_top = longint'($signed(value));
        endcase
    endtask

    task automatic set_window(logic [31:0] l, logic [31:0] r, logic [31:0] b,
                              logic [31:0] t);
        write_window(REG_LEFT, l);
        write_window(REG_RIGHT, r);
        write_window(REG_BOTTOM, b);
        write_window(REG_TOP, t);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_clips.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    // one segment transaction with random gaps before it
    task automatic send_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                                logic [31:0] ey);
        while (!quiet_sides && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ey, ex, sy, sx};
        pending_clips.insert(pending_clips.size(), clip_segment(sx, sy, ex, ey));
        do @(posedge clk); while (!s_tready);
    endtask

    // mostly near-window coordinates, some full range and edges
    function automatic logic [31:0] pick_coord(longint lo, longint hi);
        int k;
        k = $urandom_range(9);
        if (k == 0) return $urandom;
        if (k == 1) return lo[31:0];
        if (k == 2) return hi[31:0];
        if (k == 3) return 32'h8000_0000 | ($urandom_range(1) ? 32'h7fff_ffff : 32'h0);
        return clamp_coord(lo - 64'sd200000 + longint'($urandom_range(0, 400000))
                           + ((hi - lo) * $urandom_range(0, 100)) / 100);
    endfunction

    initial
    begin
        vec_t dir[$];
        vec_t v;
        clip_t miss;
        clip_t pass;
        int phase;
        cycle_count = 0;
        error_count = 0;
        quiet_sides = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_LEFT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        win_left = 0; win_right = 0; win_bottom = 0; win_top = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero window right after reset: a far segment misses
        miss = '0;
        v = '{32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'h0030_0000, 1'b1, miss};
        send_segment(v.sx, v.sy, v.ex, v.ey);
        void'(pending_clips.pop_back());
        pending_clips.insert(pending_clips.size(), v.res);
        drain_results();

        // directed table on a 10 x 10 window
        set_window(32'h0000_0000, 32'h000a_0000, 32'h0000_0000, 32'h000a_0000);
        pass = '{1'b1, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000};
        v = '{32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000, 1'b1, pass};
        dir.insert(dir.size(), v);
        v = '{32'hfffb_0000, 32'h0005_0000, 32'h000f_0000, 32'h0005_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'hfffb_0000, 32'hfffb_0000, 32'h000f_0000, 32'h000f_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h0000_0000, 32'h0000_0000, 32'h000a_0000, 32'h000a_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'hfffb_0000, 32'h0000_0000, 32'h000f_0000, 32'h0000_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h0014_0000, 32'h0014_0000, 32'h001e_0000, 32'h001e_0000, 1'b1, miss};
        dir.insert(dir.size(), v);
        v = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'hffff_ffff, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'hfffb_0000, 32'h000f_0000, 32'h000f_0000, 32'hfffb_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h0005_0000, 32'hfff6_0000, 32'h0005_0000, 32'h0014_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h8000_0000, 32'h0005_0000, 32'h7fff_ffff, 32'h0005_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h0014_0000, 32'h0000_0000, 32'h0000_0000, 32'h0014_0000, 0, miss};
        dir.insert(dir.size(), v);
        v = '{32'h000a_0000, 32'h000a_0000, 32'h0014_0000, 32'h0014_0000, 0, miss};
        dir.insert(dir.size(), v);
        foreach (dir[i])
        begin
            send_segment(dir[i].sx, dir[i].sy, dir[i].ex, dir[i].ey);
            if (dir[i].known)
            begin
                void'(pending_clips.pop_back());
                pending_clips.insert(pending_clips.size(), dir[i].res);
            end
        end
        s_tvalid <= 1'b0;
        drain_results();

        // random phases over several windows, extremes included
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_window(32'hfff0_0000, 32'h0010_0000, 32'hfff0_0000, 32'h0010_0000);
                1: set_window(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
                2: set_window(32'h0010_0000, 32'hfff0_0000, 32'h0020_0000, 32'h0001_0000);
                3: set_window(32'h7fff_fff0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0010);
                default: set_window($urandom, $urandom, $urandom, $urandom);
            endcase
            quiet_sides = (phase == 1);
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                longint lx, hx, ly, hy;
                lx = win_left < win_right ? win_left : win_right;
                hx = win_left < win_right ? win_right : win_left;
                ly = win_bottom < win_top ? win_bottom : win_top;
                hy = win_bottom < win_top ? win_top : win_bottom;
                send_segment(pick_coord(lx, hx), pick_coord(ly, hy),
                             pick_coord(lx, hx), pick_coord(ly, hy));
                // sender holds off until the pipeline is empty
                if (phase == 2 && n == 40)
                begin
                    s_tvalid <= 1'b0;
                    while (pending_clips.size() != 0) @(posedge clk);
                end
            end
            s_tvalid <= 1'b0;
            quiet_sides = 1'b0;
            drain_results();
        end

        if (error_count == 0 && pending_clips.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/core/src_pkg.sv
rtl/core/src_div_cell.sv
rtl/core/segment_rectangle_clipper_core.sv
test/segment_rectangle_clipper_core_tb.sv
